/* rtl/skl_pkg.sv */
// skl_pkg: shared constants and types for the skyline sweep block.
// No dependencies.
package skl_pkg;
  localparam int MAX_BUILDINGS = 16;
  localparam int RESULT_LIMIT  = 32;
  localparam int COORD_W       = 32;
  localparam int ENTRY_W       = 3 * COORD_W;
  localparam int IDX_W         = (MAX_BUILDINGS > 1) ? $clog2(MAX_BUILDINGS) : 1;
  localparam int CNT_W         = $clog2(MAX_BUILDINGS + 1);
  localparam int NPT_W         = $clog2(RESULT_LIMIT + 1);

  typedef logic [COORD_W-1:0] coord_t;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_EDGE  = 5'b00010,
    ST_HGT   = 5'b00100,
    ST_PUSH  = 5'b01000,
    ST_FINAL = 5'b10000
  } state_t;
endpackage

/* rtl/skl_if.sv */
// skl_if: valid/ready channel interfaces for building and key point transactions.
// Depends on skl_pkg.
interface skl_bldg_if;
  logic              valid;
  logic              ready;
  skl_pkg::coord_t   left_edge;
  skl_pkg::coord_t   right_edge;
  skl_pkg::coord_t   height;
  logic              last_building;
  modport source (output valid, left_edge, right_edge, height, last_building, input ready);
  modport sink   (input valid, left_edge, right_edge, height, last_building, output ready);
endinterface

interface skl_point_if;
  logic              valid;
  logic              ready;
  skl_pkg::coord_t   point_x;
  skl_pkg::coord_t   point_height;
  logic              last_point;
  logic              dropped;
  modport source (output valid, point_x, point_height, last_point, dropped, input ready);
  modport sink   (input valid, point_x, point_height, last_point, dropped, output ready);
endinterface

/* rtl/skl_ram.sv */
// skl_ram: generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module skl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* rtl/skyline_sweep.sv */
// skyline_sweep: building transactions are accepted only in the idle state. Per distinct
// edge the sweep scans the building RAM (one entry per cycle) twice, plus one closing
// scan; the scan rate is set by the single RAM read port. Each key point also passes
// through ST_PUSH, which can stall on the output channel. Synchronous active-high reset
// clears control state; the building RAM is not cleared. Depends on skl_pkg, skl_if,
// skl_ram.
module skyline_sweep (
  input  logic        clk,
  input  logic        rst,
  skl_bldg_if.sink    bldg,
  skl_point_if.source point
);
  import skl_pkg::*;

  state_t               state, state_next;
  logic [CNT_W-1:0]     cnt, cnt_next;
  logic                 ovf, ovf_next;
  logic [CNT_W-1:0]     idx, idx_next;
  logic                 rd_vld, rd_vld_next;
  logic                 rd_last, rd_last_next;
  logic                 first, first_next;
  coord_t               sweep_x, sweep_x_next;
  coord_t               cur_h, cur_h_next;
  coord_t               best, best_next;
  logic                 found, found_next;
  coord_t               top, top_next;
  coord_t               new_x, new_x_next;
  coord_t               new_h, new_h_next;
  coord_t               pend_x, pend_x_next;
  coord_t               pend_h, pend_h_next;
  logic                 have_pend, have_pend_next;
  logic [NPT_W-1:0]     npts, npts_next;
  logic                 ov, ov_next;
  coord_t               ox, ox_next;
  coord_t               oh, oh_next;
  logic                 olast, olast_next;
  logic                 odrop, odrop_next;

  logic                 we;
  logic [IDX_W-1:0]     raddr;
  logic [ENTRY_W-1:0]   rdata;
  logic                 acc, valid_b, store;
  logic                 out_free;
  coord_t               e0, e1, eh, b, t;
  logic                 f;

  skl_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_BUILDINGS)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (cnt[IDX_W-1:0]),
    .wdata ({bldg.left_edge, bldg.right_edge, bldg.height}),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign bldg.ready         = (state == ST_IDLE);
  assign acc                = bldg.valid && bldg.ready;
  assign valid_b            = bldg.left_edge < bldg.right_edge;
  assign store              = valid_b && (cnt < CNT_W'(MAX_BUILDINGS));
  assign we                 = acc && store;
  assign out_free           = !ov || point.ready;
  assign point.valid        = ov;
  assign point.point_x      = ox;
  assign point.point_height = oh;
  assign point.last_point   = olast;
  assign point.dropped      = odrop;
  assign e0                 = rdata[3*COORD_W-1:2*COORD_W];
  assign e1                 = rdata[2*COORD_W-1:COORD_W];
  assign eh                 = rdata[COORD_W-1:0];

  always_comb begin
    state_next     = state;
    cnt_next       = cnt;
    ovf_next       = ovf;
    idx_next       = idx;
    rd_vld_next    = 1'b0;
    rd_last_next   = 1'b0;
    first_next     = first;
    sweep_x_next   = sweep_x;
    cur_h_next     = cur_h;
    best_next      = best;
    found_next     = found;
    top_next       = top;
    new_x_next     = new_x;
    new_h_next     = new_h;
    pend_x_next    = pend_x;
    pend_h_next    = pend_h;
    have_pend_next = have_pend;
    npts_next      = npts;
    ov_next        = ov && !point.ready;
    ox_next        = ox;
    oh_next        = oh;
    olast_next     = olast;
    odrop_next     = odrop;
    raddr          = idx[IDX_W-1:0];
    b              = best;
    f              = found;
    t              = top;

    if ((state == ST_EDGE || state == ST_HGT) && idx < cnt) begin
      idx_next     = idx + CNT_W'(1);
      rd_vld_next  = 1'b1;
      rd_last_next = (idx + CNT_W'(1)) == cnt;
    end

    unique case (state)
      ST_IDLE: begin
        if (acc) begin
          if (store) begin
            cnt_next = cnt + CNT_W'(1);
          end else if (valid_b) begin
            ovf_next = 1'b1;
          end
          if (bldg.last_building) begin
            if (!store && cnt == '0) begin
              cnt_next = '0;
              ovf_next = 1'b0;
            end else begin
              state_next     = ST_EDGE;
              idx_next       = '0;
              first_next     = 1'b1;
              sweep_x_next   = '0;
              cur_h_next     = '0;
              found_next     = 1'b0;
              have_pend_next = 1'b0;
              npts_next      = '0;
            end
          end
        end
      end
      ST_EDGE: begin
        if (rd_vld) begin
          if ((first || e0 > sweep_x) && (!f || e0 < b)) begin
            b = e0;
            f = 1'b1;
          end
          if ((first || e1 > sweep_x) && (!f || e1 < b)) begin
            b = e1;
            f = 1'b1;
          end
          best_next  = b;
          found_next = f;
          if (rd_last) begin
            idx_next = '0;
            if (f) begin
              sweep_x_next = b;
              first_next   = 1'b0;
              top_next     = '0;
              state_next   = ST_HGT;
            end else if (have_pend) begin
              state_next = ST_FINAL;
            end else begin
              cnt_next   = '0;
              ovf_next   = 1'b0;
              state_next = ST_IDLE;
            end
          end
        end
      end
      ST_HGT: begin
        if (rd_vld) begin
          if (e0 <= sweep_x && sweep_x < e1 && eh > t) begin
            t = eh;
          end
          top_next = t;
          if (rd_last) begin
            idx_next   = '0;
            found_next = 1'b0;
            if (t != cur_h) begin
              cur_h_next = t;
              new_x_next = sweep_x;
              new_h_next = t;
              state_next = ST_PUSH;
            end else begin
              state_next = ST_EDGE;
            end
          end
        end
      end
      ST_PUSH: begin
        if (!have_pend || out_free) begin
          if (have_pend) begin
            ov_next    = 1'b1;
            ox_next    = pend_x;
            oh_next    = pend_h;
            olast_next = 1'b0;
            odrop_next = ovf;
          end
          pend_x_next    = new_x;
          pend_h_next    = new_h;
          have_pend_next = 1'b1;
          npts_next      = npts + NPT_W'(1);
          if ((npts + NPT_W'(1)) == NPT_W'(RESULT_LIMIT)) begin
            state_next = ST_FINAL;
          end else begin
            state_next = ST_EDGE;
          end
        end
      end
      ST_FINAL: begin
        if (out_free) begin
          ov_next        = 1'b1;
          ox_next        = pend_x;
          oh_next        = pend_h;
          olast_next     = 1'b1;
          odrop_next     = ovf;
          have_pend_next = 1'b0;
          cnt_next       = '0;
          ovf_next       = 1'b0;
          state_next     = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      ovf       <= 1'b0;
      idx       <= '0;
      rd_vld    <= 1'b0;
      rd_last   <= 1'b0;
      first     <= 1'b1;
      sweep_x   <= '0;
      cur_h     <= '0;
      found     <= 1'b0;
      have_pend <= 1'b0;
      npts      <= '0;
      ov        <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      ovf       <= ovf_next;
      idx       <= idx_next;
      rd_vld    <= rd_vld_next;
      rd_last   <= rd_last_next;
      first     <= first_next;
      sweep_x   <= sweep_x_next;
      cur_h     <= cur_h_next;
      found     <= found_next;
      have_pend <= have_pend_next;
      npts      <= npts_next;
      ov        <= ov_next;
    end
  end

  always_ff @(posedge clk) begin
    best   <= best_next;
    top    <= top_next;
    new_x  <= new_x_next;
    new_h  <= new_h_next;
    pend_x <= pend_x_next;
    pend_h <= pend_h_next;
    ox     <= ox_next;
    oh     <= oh_next;
    olast  <= olast_next;
    odrop  <= odrop_next;
  end

`ifndef ASSERT_OFF
  a_cnt_max: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(MAX_BUILDINGS))
    else $error("building count above capacity");

  a_npts_max: assert property (@(posedge clk) disable iff (rst)
    npts <= NPT_W'(RESULT_LIMIT))
    else $error("key point count above limit");

  a_rd_in_scan: assert property (@(posedge clk) disable iff (rst)
    rd_vld |-> (state == ST_EDGE || state == ST_HGT))
    else $error("read data outside a scan");

  a_final_pend: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FINAL) |-> have_pend)
    else $error("final transaction without a pending point");
`endif
endmodule

/* tb/skyline_sweep_chk.sv */
// skyline_sweep_chk: watches the building and key point channels, predicts the skyline
// and compares each key point transaction. Depends on skl_pkg and skl_if.
module skyline_sweep_chk (
  input  logic        clk,
  input  logic        rst,
  skl_bldg_if.sink    bldg,
  skl_point_if.sink   point,
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import skl_pkg::*;

  typedef struct packed {
    coord_t x;
    coord_t h;
    logic   last;
    logic   drop;
  } key_point_t;

  coord_t     lefts[MAX_BUILDINGS];
  coord_t     rights[MAX_BUILDINGS];
  coord_t     heights[MAX_BUILDINGS];
  int         n_stored;
  logic       overflowed;
  key_point_t skyline_q[$];

  function automatic coord_t top_at(coord_t x);
    coord_t t;
    t = '0;
    for (int i = 0; i < n_stored; i++)
      if (lefts[i] <= x && x < rights[i] && heights[i] > t) t = heights[i];
    return t;
  endfunction

  task automatic add_building(coord_t l, coord_t r, coord_t h, logic fin);
    coord_t     x, cur, t, best;
    bit         found, first;
    int         n, base;
    key_point_t kp;
    if (l < r) begin
      if (n_stored < MAX_BUILDINGS) begin
        lefts[n_stored] = l;
        rights[n_stored] = r;
        heights[n_stored] = h;
        n_stored++;
      end else begin
        overflowed = 1'b1;
      end
    end
    if (!fin) return;
    cur = '0;
    x = '0;
    first = 1'b1;
    n = 0;
    base = skyline_q.size();
    forever begin
      found = 1'b0;
      best = '0;
      for (int i = 0; i < n_stored; i++) begin
        if ((first || lefts[i] > x) && (!found || lefts[i] < best)) begin
          best = lefts[i]; found = 1'b1;
        end
        if ((first || rights[i] > x) && (!found || rights[i] < best)) begin
          best = rights[i]; found = 1'b1;
        end
      end
      if (!found) break;
      first = 1'b0;
      x = best;
      t = top_at(x);
      if (t != cur) begin
        if (n < RESULT_LIMIT) begin
          kp.x = x; kp.h = t; kp.last = 1'b0; kp.drop = overflowed;
          skyline_q.insert(skyline_q.size(), kp);
          n++;
        end
        cur = t;
      end
    end
    if (n > 0) skyline_q[base + n - 1].last = 1'b1;
    n_stored = 0;
    overflowed = 1'b0;
  endtask

  always @(posedge clk) begin
    key_point_t e;
    int         errs;
    errs = 0;
    if (rst) begin
      n_stored = 0;
      overflowed = 1'b0;
      fail_count <= 0;
      skyline_q.delete();
    end else begin
      if (point.valid && point.ready) begin
        if (skyline_q.size() == 0) begin
          $error("unexpected key point x=%0d h=%0d", point.point_x, point.point_height);
          errs++;
        end else begin
          e = skyline_q.pop_front();
          if (point.point_x !== e.x) begin
            $error("point_x expected %0d actual %0d", e.x, point.point_x);
            errs++;
          end
          if (point.point_height !== e.h) begin
            $error("point_height expected %0d actual %0d", e.h, point.point_height);
            errs++;
          end
          if (point.last_point !== e.last) begin
            $error("last_point expected %0d actual %0d", e.last, point.last_point);
            errs++;
          end
          if (point.dropped !== e.drop) begin
            $error("dropped expected %0d actual %0d", e.drop, point.dropped);
            errs++;
          end
        end
      end
      if (bldg.valid && bldg.ready)
        add_building(bldg.left_edge, bldg.right_edge, bldg.height, bldg.last_building);
      if (errs != 0) fail_count <= fail_count + errs;
    end
    pending <= skyline_q.size();
  end
endmodule

/* tb/skyline_sweep_tb.sv */
// skyline_sweep_tb: drives building transactions with random gaps and back-pressure,
// and reports the verdict. Depends on skl_pkg, skl_if, skyline_sweep, skyline_sweep_chk.
module skyline_sweep_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import skl_pkg::*;

  localparam int CYCLE_LIMIT = 2000000;

  logic clk;
  logic rst;
  int   fail_count;
  int   pending;
  int   cycles;
  bit   stim_done;

  skl_bldg_if  bldg ();
  skl_point_if point ();

  skyline_sweep dut (.clk(clk), .rst(rst), .bldg(bldg), .point(point));
  skyline_sweep_chk chk (.clk(clk), .rst(rst), .bldg(bldg), .point(point),
                         .fail_count(fail_count), .pending(pending));

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic coord_t rand_coord(int mode);
    case (mode)
      0: return $urandom_range(0, 40);
      1: return 32'hFFFF_FFFF - $urandom_range(0, 40);
      default: return $urandom();
    endcase
  endfunction

  task automatic send(coord_t l, coord_t r, coord_t h, logic fin);
    int gap;
    gap = $urandom_range(0, 14);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      bldg.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    bldg.valid <= 1'b1;
    bldg.left_edge <= l;
    bldg.right_edge <= r;
    bldg.height <= h;
    bldg.last_building <= fin;
    @(posedge clk);
    while (!bldg.ready) @(posedge clk);
  endtask

  initial begin
    int mode, nb;
    coord_t l, r;
    point.ready = 1'b0;
    bldg.valid = 1'b0;
    bldg.left_edge = '0;
    bldg.right_edge = '0;
    bldg.height = '0;
    bldg.last_building = 1'b0;
    rst = 1'b1;
    stim_done = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send(0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    send(5, 5, 9, 1'b1);
    send(9, 3, 9, 1'b0);
    send(1, 4, 0, 1'b1);
    send(1, 5, 3, 1'b0);
    send(5, 8, 3, 1'b0);
    send(2, 5, 7, 1'b0);
    send(2, 6, 7, 1'b1);
    for (int i = 0; i < 18; i++)
      send(i, i + 2, i + 1, i == 17);
    for (int i = 0; i < 16; i++)
      send(32'hFFFF_FFF0 + i, 32'hFFFF_FFFF, 32'hFFFF_FFFF - i, i == 15);
    for (int k = 0; k < 400; ) begin
      nb = $urandom_range(1, 18);
      mode = $urandom_range(0, 2);
      for (int j = 0; j < nb; j++) begin
        l = rand_coord(mode);
        r = rand_coord(mode);
        if ($urandom_range(0, 9) != 0 && l > r) begin
          coord_t t; t = l; l = r; r = t;
        end
        send(l, r, ($urandom_range(0, 5) == 0) ? $urandom() : $urandom_range(0, 9),
             (j == nb - 1) ? 1'b1 : 1'b0);
        k++;
      end
    end
    bldg.valid <= 1'b0;
    stim_done = 1'b1;
  end

  initial begin
    int stall;
    @(negedge rst);
    forever begin
      stall = $urandom_range(0, 14);
      if ($urandom_range(0, 3) == 0) stall = 0;
      if (stall > 0) begin
        point.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      point.ready <= 1'b1;
      @(posedge clk);
      while (!point.valid) @(posedge clk);
    end
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("skyline_sweep verification failed");
        $finish;
      end
    end
  end

  initial begin
    wait (stim_done);
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (2000) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("skyline_sweep verification clean");
    end else begin
      $display("skyline_sweep verification failed");
    end
    $finish;
  end
endmodule
